// ===== rtl/core/pru_pkg.sv =====
// ----------------------------------------------------------------------------
// pru_pkg
// shared types, constants and helpers for the pixel replication upscaler
// ----------------------------------------------------------------------------
package pru_pkg;

   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam int SCALE_W           = 7;
   localparam int WIDTH_W           = 13;
   localparam int COLOUR_W          = 8;
   localparam int PAD_W             = 2;
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = WIDTH_W;

   // scale values at or above this limit act as one less
   localparam logic [SCALE_W-1:0] SCALE_LIMIT = SCALE_W'(100);

   localparam logic [CSR_INDEX_W-1:0] REG_SCALE     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_WIDTH = 1'b1;

   typedef enum logic {
      ACTION_PIXEL = 1'b0,
      ACTION_TICK  = 1'b1
   } action_type;

   typedef enum logic {
      KIND_RUN    = 1'b0,
      KIND_REJECT = 1'b1
   } kind_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } pixel_type;

   // clamp raw scale register into 1..99
   function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] raw);
      logic [SCALE_W-1:0] res;
      if (raw == '0) begin
         res = SCALE_W'(1);
      end else if (raw >= SCALE_LIMIT) begin
         res = SCALE_LIMIT - SCALE_W'(1);
      end else begin
         res = raw;
      end
      return res;
   endfunction

   // (4 - w*s*3 mod 4) mod 4 reduces to (w*s) mod 4
   function automatic logic [PAD_W-1:0] row_pad(input logic [1:0] w_lo,
                                                input logic [1:0] s_lo);
      logic [3:0] prod;
      prod = w_lo * s_lo;
      return prod[PAD_W-1:0];
   endfunction

endpackage

// ===== rtl/core/pru_stream_if.sv =====
// ----------------------------------------------------------------------------
// pru_req_if / pru_rsp_if
// valid/ready channels for incoming words and emitted runs
// ----------------------------------------------------------------------------
interface pru_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [pru_pkg::COLOUR_W-1:0] red;
   logic [pru_pkg::COLOUR_W-1:0] green;
   logic [pru_pkg::COLOUR_W-1:0] blue;

   modport source (output valid, action, red, green, blue, input ready);
   modport sink   (input valid, action, red, green, blue, output ready);
endinterface

interface pru_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [pru_pkg::COLOUR_W-1:0] out_red;
   logic [pru_pkg::COLOUR_W-1:0] out_green;
   logic [pru_pkg::COLOUR_W-1:0] out_blue;
   logic [pru_pkg::SCALE_W-1:0]  repeat_count;
   logic [pru_pkg::PAD_W-1:0]    pad_after;
   logic                         row_end;

   modport source (output valid, kind, out_red, out_green, out_blue,
                   repeat_count, pad_after, row_end, input ready);
   modport sink   (input valid, kind, out_red, out_green, out_blue,
                   repeat_count, pad_after, row_end, output ready);
endinterface

// ===== rtl/core/pru_line_buffer.sv =====
// ----------------------------------------------------------------------------
// pru_line_buffer
// single-port-write, registered-read line store for one input row
// ----------------------------------------------------------------------------
module pru_line_buffer #(
   parameter int MAX_WIDTH = pru_pkg::DEFAULT_MAX_WIDTH,
   parameter int AW        = $clog2(MAX_WIDTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  pru_pkg::pixel_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output pru_pkg::pixel_type rd_data
);

   pru_pkg::pixel_type mem [MAX_WIDTH];
   pru_pkg::pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pixel_replication_upscaler_core.sv =====
// ----------------------------------------------------------------------------
// pixel_replication_upscaler_core
// integer nearest-neighbour upscaler: each pixel becomes a run of scale copies,
// the stored row is replayed scale-1 times on tick words, rows padded to 4 bytes
// ----------------------------------------------------------------------------
// throughput: one input word per cycle, ticks and pixels alike, while the output
//   register is not stalled by rsp_if.ready; an accepted word passes through stage 1
//   (with the line store read register for replay words), then the output register
// reset: synchronous; clears columns, replay state and pipeline valids, sets
//   scale and row_width to 1; the line store itself is not cleared
// ----------------------------------------------------------------------------
module pixel_replication_upscaler_core #(
   parameter int MAX_WIDTH = pru_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   pru_req_if.sink                           req_if,
   pru_rsp_if.source                         rsp_if,
   input  logic                              csr_wr_en,
   input  logic [pru_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pru_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int AW   = $clog2(MAX_WIDTH);
   // compare width: holds MAX_WIDTH and the raw row_width register
   localparam int CMPW = (AW + 1 > pru_pkg::WIDTH_W) ? AW + 1 : pru_pkg::WIDTH_W;

   typedef struct packed {
      logic                         kind;
      logic                         from_mem;
      pru_pkg::pixel_type           pixel;
      logic [pru_pkg::SCALE_W-1:0]  repeat_count;
      logic [pru_pkg::PAD_W-1:0]    pad_after;
      logic                         row_end;
   } stage_type;

   // configuration registers
   logic [pru_pkg::SCALE_W-1:0] scale_ff;
   logic [pru_pkg::WIDTH_W-1:0] row_width_ff;

   // row state
   logic [AW-1:0]               fill_column_ff, fill_column_in;
   logic                        replaying_ff, replaying_in;
   logic [AW-1:0]               replay_column_ff, replay_column_in;
   logic [pru_pkg::SCALE_W-1:0] rows_left_ff, rows_left_in;

   // pipeline
   logic                        s1_valid_ff;
   stage_type                   s1_info_ff, s1_info_in;
   stage_type                   s1_out;
   logic                        rsp_valid_ff;
   stage_type                   rsp_info_ff;

   logic                        accept, out_advance, req_ready;
   logic                        is_pixel, s1_valid_in;
   logic                        wr_en, rd_en;
   logic [pru_pkg::SCALE_W-1:0] scale_eff;
   logic [CMPW-1:0]             width_raw, width_eff;
   logic [CMPW-1:0]             fill_next, replay_next;
   logic                        fill_last, replay_last;
   logic [pru_pkg::PAD_W-1:0]   pad;
   pru_pkg::pixel_type          in_pixel, rd_pixel;
   logic [pru_pkg::SCALE_W-1:0] rows_dec;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= pru_pkg::SCALE_W'(1);
         row_width_ff <= pru_pkg::WIDTH_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            pru_pkg::REG_SCALE:     scale_ff     <= csr_wr_data[pru_pkg::SCALE_W-1:0];
            pru_pkg::REG_ROW_WIDTH: row_width_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // effective registers: out-of-range values clamp
   always_comb begin
      scale_eff = pru_pkg::eff_scale(scale_ff);
      width_raw = CMPW'(row_width_ff);
      if (width_raw == '0) begin
         width_eff = CMPW'(1);
      end else if (width_raw > CMPW'(MAX_WIDTH)) begin
         width_eff = CMPW'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      pad = pru_pkg::row_pad(width_eff[1:0], scale_eff[1:0]);
   end

   // ------------------------------------------------------------- handshake
   assign out_advance   = !rsp_valid_ff || rsp_if.ready;
   assign req_ready     = !s1_valid_ff || out_advance;
   assign req_if.ready  = req_ready;
   assign accept        = req_if.valid && req_ready;
   assign is_pixel      = (req_if.action == pru_pkg::ACTION_PIXEL);

   assign in_pixel.red   = req_if.red;
   assign in_pixel.green = req_if.green;
   assign in_pixel.blue  = req_if.blue;

   // store writes only outside replay, reads only inside it: never the same cycle
   assign wr_en = accept && is_pixel && !replaying_ff;
   assign rd_en = accept && !is_pixel && replaying_ff;

   // ------------------------------------------------------ next row state
   always_comb begin
      fill_column_in   = fill_column_ff;
      replaying_in     = replaying_ff;
      replay_column_in = replay_column_ff;
      rows_left_in     = rows_left_ff;

      fill_next   = CMPW'(fill_column_ff) + CMPW'(1);
      replay_next = CMPW'(replay_column_ff) + CMPW'(1);
      fill_last   = (fill_next >= width_eff);
      replay_last = (replay_next >= width_eff);
      rows_dec    = (rows_left_ff != '0) ? rows_left_ff - pru_pkg::SCALE_W'(1) : '0;

      s1_valid_in           = accept && (is_pixel || replaying_ff);
      s1_info_in.kind       = pru_pkg::KIND_RUN;
      s1_info_in.from_mem   = 1'b0;
      s1_info_in.pixel      = in_pixel;
      s1_info_in.repeat_count = scale_eff;
      s1_info_in.pad_after  = '0;
      s1_info_in.row_end    = 1'b0;

      if (is_pixel && replaying_ff) begin
         // pixel during replay: rejected, nothing changes
         s1_info_in.kind         = pru_pkg::KIND_REJECT;
         s1_info_in.pixel        = '0;
         s1_info_in.repeat_count = '0;
      end else if (is_pixel) begin
         s1_info_in.row_end   = fill_last;
         s1_info_in.pad_after = fill_last ? pad : '0;
         if (accept) begin
            if (fill_last) begin
               fill_column_in = '0;
               if (scale_eff > pru_pkg::SCALE_W'(1)) begin
                  replaying_in     = 1'b1;
                  replay_column_in = '0;
                  rows_left_in     = scale_eff - pru_pkg::SCALE_W'(1);
               end
            end else begin
               fill_column_in = fill_column_ff + AW'(1);
            end
         end
      end else if (replaying_ff) begin
         // tick: replay the stored entry
         s1_info_in.from_mem  = 1'b1;
         s1_info_in.row_end   = replay_last;
         s1_info_in.pad_after = replay_last ? pad : '0;
         if (accept) begin
            if (replay_last) begin
               replay_column_in = '0;
               rows_left_in     = rows_dec;
               if (rows_dec == '0) begin
                  replaying_in = 1'b0;
               end
            end else begin
               replay_column_in = replay_column_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_column_ff   <= '0;
         replaying_ff     <= 1'b0;
         replay_column_ff <= '0;
         rows_left_ff     <= '0;
      end else begin
         fill_column_ff   <= fill_column_in;
         replaying_ff     <= replaying_in;
         replay_column_ff <= replay_column_in;
         rows_left_ff     <= rows_left_in;
      end
   end

   // ------------------------------------------------------------ line store
   pru_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_line_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_column_ff),
      .wr_data (in_pixel),
      .rd_en   (rd_en),
      .rd_addr (replay_column_ff),
      .rd_data (rd_pixel)
   );

   // ------------------------------------------- stage 1: store read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= s1_info_in;
      end
   end

   // replay words take their pixel from the store read register
   always_comb begin
      s1_out = s1_info_ff;
      if (s1_info_ff.from_mem) begin
         s1_out.pixel = rd_pixel;
      end
   end

   // -------------------------------------- output register, parts both sides
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance && s1_valid_ff) begin
         rsp_info_ff <= s1_out;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kind         = rsp_info_ff.kind;
   assign rsp_if.out_red      = rsp_info_ff.pixel.red;
   assign rsp_if.out_green    = rsp_info_ff.pixel.green;
   assign rsp_if.out_blue     = rsp_info_ff.pixel.blue;
   assign rsp_if.repeat_count = rsp_info_ff.repeat_count;
   assign rsp_if.pad_after    = rsp_info_ff.pad_after;
   assign rsp_if.row_end      = rsp_info_ff.row_end;

   // ------------------------------------------------------------ assertions
   // replay always has at least one row outstanding
   a_replay_rows: assert property (@(posedge clock) disable iff (reset)
      replaying_ff |-> rows_left_ff != '0)
      else $error("replay active with no rows left");

   // filling restarts at column zero before replay begins
   a_fill_idle_in_replay: assert property (@(posedge clock) disable iff (reset)
      replaying_ff |-> fill_column_ff == '0)
      else $error("fill column nonzero during replay");

   // stalled read data must not move under a waiting stage 1 word
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_advance |=> $stable(rd_pixel))
      else $error("line store read data changed while stalled");

   // a rejected word carries an empty run
   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_info_ff.kind == pru_pkg::KIND_REJECT
         |-> rsp_info_ff.repeat_count == '0 && !rsp_info_ff.row_end)
      else $error("rejected word with nonzero run");

   // store is never written and read in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("line store write and read collide");

endmodule
